/* rtl/psle_pkg.sv */
// Shared types, constants and key maps for the scan code line editor.
// Used by psle_front, psle_cmdq, psle_back and the top level; no dependencies.
`default_nettype none

package psle_pkg;

  // Widths of the result fields.
  localparam int PosW  = 7;
  localparam int CharW = 7;
  localparam int KindW = 3;

  // Scan code set 1 bytes of interest.
  localparam logic [7:0] SC_PREFIX     = 8'hE0;
  localparam logic [7:0] SC_LEFT       = 8'h4B;
  localparam logic [7:0] SC_RIGHT      = 8'h4D;
  localparam logic [7:0] SC_LSHIFT     = 8'h2A;
  localparam logic [7:0] SC_RSHIFT     = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;

  // Control characters from the key maps.
  localparam logic [CharW-1:0] CH_NONE  = 7'h00;
  localparam logic [CharW-1:0] CH_BKSP  = 7'h08;
  localparam logic [CharW-1:0] CH_ENTER = 7'h0A;

  // Result event kinds.
  localparam logic [KindW-1:0] EV_INSERT = 3'd0;
  localparam logic [KindW-1:0] EV_DELETE = 3'd1;
  localparam logic [KindW-1:0] EV_LEFT   = 3'd2;
  localparam logic [KindW-1:0] EV_RIGHT  = 3'd3;
  localparam logic [KindW-1:0] EV_CHAR   = 3'd4;
  localparam logic [KindW-1:0] EV_END    = 3'd5;

  // Edit commands handed from the front to the back.
  typedef enum logic [2:0] {
    OP_LEFT,
    OP_RIGHT,
    OP_BKSP,
    OP_ENTER,
    OP_INSERT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t          op;
    logic [CharW-1:0] ch;
  } cmd_t;

  // Plain and shifted key maps, indexed by the low seven bits of a make code.
  function automatic logic [CharW-1:0] key_map(input logic [6:0] idx, input logic shifted);
    logic [CharW-1:0] r;
    r = CH_NONE;
    case (idx)
      7'h01: r = 7'h1B;
      7'h02: r = shifted ? 7'h21 : 7'h31;
      7'h03: r = shifted ? 7'h40 : 7'h32;
      7'h04: r = shifted ? 7'h23 : 7'h33;
      7'h05: r = shifted ? 7'h24 : 7'h34;
      7'h06: r = shifted ? 7'h25 : 7'h35;
      7'h07: r = shifted ? 7'h5E : 7'h36;
      7'h08: r = shifted ? 7'h26 : 7'h37;
      7'h09: r = shifted ? 7'h2A : 7'h38;
      7'h0A: r = shifted ? 7'h28 : 7'h39;
      7'h0B: r = shifted ? 7'h29 : 7'h30;
      7'h0C: r = shifted ? 7'h5F : 7'h2D;
      7'h0D: r = shifted ? 7'h2B : 7'h3D;
      7'h0E: r = CH_BKSP;
      7'h0F: r = 7'h09;
      7'h10: r = shifted ? 7'h51 : 7'h71;
      7'h11: r = shifted ? 7'h57 : 7'h77;
      7'h12: r = shifted ? 7'h45 : 7'h65;
      7'h13: r = shifted ? 7'h52 : 7'h72;
      7'h14: r = shifted ? 7'h54 : 7'h74;
      7'h15: r = shifted ? 7'h59 : 7'h79;
      7'h16: r = shifted ? 7'h55 : 7'h75;
      7'h17: r = shifted ? 7'h49 : 7'h69;
      7'h18: r = shifted ? 7'h4F : 7'h6F;
      7'h19: r = shifted ? 7'h50 : 7'h70;
      7'h1A: r = shifted ? 7'h7B : 7'h5B;
      7'h1B: r = shifted ? 7'h7D : 7'h5D;
      7'h1C: r = CH_ENTER;
      7'h1E: r = shifted ? 7'h41 : 7'h61;
      7'h1F: r = shifted ? 7'h53 : 7'h73;
      7'h20: r = shifted ? 7'h44 : 7'h64;
      7'h21: r = shifted ? 7'h46 : 7'h66;
      7'h22: r = shifted ? 7'h47 : 7'h67;
      7'h23: r = shifted ? 7'h48 : 7'h68;
      7'h24: r = shifted ? 7'h4A : 7'h6A;
      7'h25: r = shifted ? 7'h4B : 7'h6B;
      7'h26: r = shifted ? 7'h4C : 7'h6C;
      7'h27: r = shifted ? 7'h3A : 7'h3B;
      7'h28: r = shifted ? 7'h22 : 7'h27;
      7'h29: r = shifted ? 7'h7E : 7'h60;
      7'h2B: r = shifted ? 7'h7C : 7'h5C;
      7'h2C: r = shifted ? 7'h5A : 7'h7A;
      7'h2D: r = shifted ? 7'h58 : 7'h78;
      7'h2E: r = shifted ? 7'h43 : 7'h63;
      7'h2F: r = shifted ? 7'h56 : 7'h76;
      7'h30: r = shifted ? 7'h42 : 7'h62;
      7'h31: r = shifted ? 7'h4E : 7'h6E;
      7'h32: r = shifted ? 7'h4D : 7'h6D;
      7'h33: r = shifted ? 7'h3C : 7'h2C;
      7'h34: r = shifted ? 7'h3E : 7'h2E;
      7'h35: r = shifted ? 7'h3F : 7'h2F;
      7'h37: r = 7'h2A;
      7'h39: r = 7'h20;
      default: r = CH_NONE;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/psle_front.sv */
// Front end: tracks shift and prefix state and turns scan bytes into edit commands.
// Depends on psle_pkg for the scan codes, key maps and command type.
`default_nettype none

module psle_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          acc,
  input  wire logic [7:0]    scan_byte,
  output psle_pkg::cmd_t     cmd,
  output logic               cmd_push
);
  import psle_pkg::*;

  logic             shift_r, shift_nxt;
  logic             prefix_r, prefix_nxt;
  logic             has_cmd;
  logic [CharW-1:0] key;

  // Classify the byte and work out the next shift and prefix state.
  always_comb begin
    shift_nxt  = shift_r;
    prefix_nxt = prefix_r;
    has_cmd    = 1'b0;
    cmd.op     = OP_INSERT;
    cmd.ch     = CH_NONE;
    key        = CH_NONE;
    if (scan_byte == SC_PREFIX) begin
      prefix_nxt = 1'b1;
    end else if (prefix_r) begin
      prefix_nxt = 1'b0;
      if (scan_byte == SC_LEFT) begin
        has_cmd = 1'b1;
        cmd.op  = OP_LEFT;
      end else if (scan_byte == SC_RIGHT) begin
        has_cmd = 1'b1;
        cmd.op  = OP_RIGHT;
      end
    end else begin
      if (scan_byte == SC_LSHIFT || scan_byte == SC_RSHIFT) begin
        shift_nxt = 1'b1;
      end
      if (scan_byte == SC_LSHIFT_BRK || scan_byte == SC_RSHIFT_BRK) begin
        shift_nxt = 1'b0;
      end
      if (!scan_byte[7]) begin
        key = key_map(scan_byte[6:0], shift_nxt);
        if (key == CH_BKSP) begin
          has_cmd = 1'b1;
          cmd.op  = OP_BKSP;
        end else if (key == CH_ENTER) begin
          has_cmd = 1'b1;
          cmd.op  = OP_ENTER;
        end else if (key != CH_NONE) begin
          has_cmd = 1'b1;
          cmd.op  = OP_INSERT;
          cmd.ch  = key;
        end
      end
    end
  end

  assign cmd_push = acc && has_cmd;

  // Shift and prefix state advance only on an accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r  <= 1'b0;
      prefix_r <= 1'b0;
    end else if (acc) begin
      shift_r  <= shift_nxt;
      prefix_r <= prefix_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/psle_cmdq.sv */
// Two-entry command queue between the front end and the line back end.
// Depends on psle_pkg for the command type.
`default_nettype none

module psle_cmdq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire psle_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output psle_pkg::cmd_t      head,
  output logic                avail
);
  import psle_pkg::*;

  cmd_t       entry_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign avail   = (cnt_r != 2'd0);
  assign head    = entry_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && avail;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wp_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

/* rtl/psle_back.sv */
// Back end: owns the line memory, cursor and length, and carries out edit commands.
// Depends on psle_pkg for the command type, event kinds and field widths.
`default_nettype none

module psle_back #(
  parameter int LINE_CAPACITY = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire psle_pkg::cmd_t              cmd,
  input  wire logic                        cmd_avail,
  output logic                             cmd_pop,
  output logic                             out_empty,
  input  wire logic                        out_pop,
  output logic [psle_pkg::KindW-1:0]       out_event_kind,
  output logic [psle_pkg::CharW-1:0]       out_char_code,
  output logic [psle_pkg::PosW-1:0]        out_cursor_pos,
  output logic [psle_pkg::PosW-1:0]        out_line_len,
  output logic                             out_last
);
  import psle_pkg::*;

  localparam int AW = $clog2(LINE_CAPACITY);
  localparam logic [AW-1:0] LAST_IDX = AW'(LINE_CAPACITY - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_DRAIN,
    S_PUT,
    S_RESULT,
    S_EMIT,
    S_END
  } state_t;

  state_t           state_r, state_nxt;
  logic [AW-1:0]    len_r, len_nxt;
  logic [AW-1:0]    cur_r, cur_nxt;
  logic [AW-1:0]    rd_r, rd_nxt;
  logic [AW-1:0]    stop_r, stop_nxt;
  logic [AW-1:0]    cnt_r, cnt_nxt;
  logic             up_r, up_nxt;
  logic             wpend_r, wpend_nxt;
  logic [AW-1:0]    wpa_r, wpa_nxt;
  logic [CharW-1:0] ch_r, ch_nxt;
  logic [KindW-1:0] kind_r, kind_nxt;

  logic             ov_r, ov_nxt;
  logic [KindW-1:0] ok_r, ok_nxt;
  logic [CharW-1:0] oc_r, oc_nxt;
  logic [PosW-1:0]  opos_r, opos_nxt;
  logic [PosW-1:0]  olen_r, olen_nxt;
  logic             olast_r, olast_nxt;

  logic [CharW-1:0] line_mem [LINE_CAPACITY];
  logic [CharW-1:0] rdata_r;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [CharW-1:0] mem_wd;
  logic             out_ok;
  logic [PosW-1:0]  cur_ext, len_ext;

  assign out_ok  = !ov_r || out_pop;
  assign cur_ext = {{(PosW-AW){1'b0}}, cur_r};
  assign len_ext = {{(PosW-AW){1'b0}}, len_r};

  // Command sequencer and output register next-state logic.
  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    cur_nxt   = cur_r;
    rd_nxt    = rd_r;
    stop_nxt  = stop_r;
    cnt_nxt   = cnt_r;
    up_nxt    = up_r;
    wpend_nxt = 1'b0;
    wpa_nxt   = wpa_r;
    ch_nxt    = ch_r;
    kind_nxt  = kind_r;
    ov_nxt    = ov_r && !out_pop;
    ok_nxt    = ok_r;
    oc_nxt    = oc_r;
    opos_nxt  = opos_r;
    olen_nxt  = olen_r;
    olast_nxt = olast_r;
    cmd_pop   = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = rd_r;
    mem_we    = wpend_r;
    mem_wa    = wpa_r;
    mem_wd    = rdata_r;

    case (state_r)
      S_IDLE: begin
        if (cmd_avail) begin
          cmd_pop = 1'b1;
          ch_nxt  = CH_NONE;
          case (cmd.op)
            OP_LEFT: begin
              if (cur_r != '0) begin
                cur_nxt   = cur_r - 1'b1;
                kind_nxt  = EV_LEFT;
                state_nxt = S_RESULT;
              end
            end
            OP_RIGHT: begin
              if (cur_r < len_r) begin
                cur_nxt   = cur_r + 1'b1;
                kind_nxt  = EV_RIGHT;
                state_nxt = S_RESULT;
              end
            end
            OP_BKSP: begin
              // Pull the tail one place left, over the deleted character.
              if (cur_r != '0) begin
                cur_nxt  = cur_r - 1'b1;
                len_nxt  = len_r - 1'b1;
                kind_nxt = EV_DELETE;
                rd_nxt   = cur_r;
                stop_nxt = len_r - 1'b1;
                up_nxt   = 1'b0;
                state_nxt = (cur_r < len_r) ? S_SHIFT : S_RESULT;
              end
            end
            OP_ENTER: begin
              len_nxt = '0;
              cur_nxt = '0;
              cnt_nxt = len_r;
              rd_nxt  = '0;
              if (len_r == '0) begin
                state_nxt = S_END;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                state_nxt = S_EMIT;
              end
            end
            OP_INSERT: begin
              // Push the tail one place right, then write the new character.
              if (len_r < LAST_IDX) begin
                kind_nxt  = EV_INSERT;
                ch_nxt    = cmd.ch;
                stop_nxt  = cur_r;
                rd_nxt    = len_r - 1'b1;
                up_nxt    = 1'b1;
                len_nxt   = len_r + 1'b1;
                cur_nxt   = cur_r + 1'b1;
                state_nxt = (len_r == cur_r) ? S_PUT : S_SHIFT;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SHIFT: begin
        // Read one entry a cycle; each write lands in the cycle after its read.
        rd_en     = 1'b1;
        rd_addr   = rd_r;
        wpend_nxt = 1'b1;
        wpa_nxt   = up_r ? rd_r + 1'b1 : rd_r - 1'b1;
        if (rd_r == stop_r) begin
          state_nxt = S_DRAIN;
        end else begin
          rd_nxt = up_r ? rd_r - 1'b1 : rd_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = up_r ? S_PUT : S_RESULT;
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_wa    = stop_r;
        mem_wd    = ch_r;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (out_ok) begin
          ov_nxt    = 1'b1;
          ok_nxt    = kind_r;
          oc_nxt    = ch_r;
          opos_nxt  = cur_ext;
          olen_nxt  = len_ext;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        // Read data holds until the next read, so a stall just waits here.
        if (out_ok) begin
          ov_nxt    = 1'b1;
          ok_nxt    = EV_CHAR;
          oc_nxt    = rdata_r;
          opos_nxt  = cur_ext;
          olen_nxt  = len_ext;
          olast_nxt = 1'b0;
          if (rd_r + 1'b1 == cnt_r) begin
            state_nxt = S_END;
          end else begin
            rd_en   = 1'b1;
            rd_addr = rd_r + 1'b1;
            rd_nxt  = rd_r + 1'b1;
          end
        end
      end
      S_END: begin
        if (out_ok) begin
          ov_nxt    = 1'b1;
          ok_nxt    = EV_END;
          oc_nxt    = CH_NONE;
          opos_nxt  = cur_ext;
          olen_nxt  = len_ext;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
      cur_r   <= '0;
      wpend_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      cur_r   <= cur_nxt;
      wpend_r <= wpend_nxt;
      ov_r    <= ov_nxt;
    end
    rd_r    <= rd_nxt;
    stop_r  <= stop_nxt;
    cnt_r   <= cnt_nxt;
    up_r    <= up_nxt;
    wpa_r   <= wpa_nxt;
    ch_r    <= ch_nxt;
    kind_r  <= kind_nxt;
    ok_r    <= ok_nxt;
    oc_r    <= oc_nxt;
    opos_r  <= opos_nxt;
    olen_r  <= olen_nxt;
    olast_r <= olast_nxt;
  end

  // Line memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rdata_r <= line_mem[rd_addr];
    end
  end

  assign out_empty      = !ov_r;
  assign out_event_kind = ok_r;
  assign out_char_code  = oc_r;
  assign out_cursor_pos = opos_r;
  assign out_line_len   = olen_r;
  assign out_last       = olast_r;

endmodule

`default_nettype wire

/* rtl/ps2_scancode_line_editor.sv */
// Top level of the scan code set 1 line editor.
// Instantiates psle_front, psle_cmdq and psle_back; depends on psle_pkg.
//
//   Channel   Handshake              Payload
//   -------   --------------------   ------------------------------------------------
//   input     in_push / in_full      in_scan_byte
//   result    out_pop / out_empty    out_event_kind, out_char_code, out_cursor_pos,
//                                    out_line_len, out_last
//
// The front classifies a byte in the cycle it is taken and queues at most one command.
// A cursor move goes straight from idle to its result in the back end, and an edit at
// the line end writes at most the new character first; an insert or delete moves the
// tail one entry a cycle through the line memory, which has a write port and a registered read port.
// Enter sends one result a cycle while the results are popped. Reset clears control
// state only; the line memory is not cleared. A stalled result holds the back end, and
// bytes keep being taken until the two-entry command queue fills.
`default_nettype none

module ps2_scancode_line_editor #(
  parameter int LINE_CAPACITY = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_push,
  output logic                             in_full,
  input  wire logic [7:0]                  in_scan_byte,
  output logic                             out_empty,
  input  wire logic                        out_pop,
  output logic [psle_pkg::KindW-1:0]       out_event_kind,
  output logic [psle_pkg::CharW-1:0]       out_char_code,
  output logic [psle_pkg::PosW-1:0]        out_cursor_pos,
  output logic [psle_pkg::PosW-1:0]        out_line_len,
  output logic                             out_last
);
  import psle_pkg::*;

  logic acc;
  cmd_t f_cmd;
  logic f_push;
  cmd_t q_head;
  logic q_avail;
  logic q_pop;

  assign acc = in_push && !in_full;

  // Byte classification and shift tracking.
  psle_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .scan_byte (in_scan_byte),
    .cmd       (f_cmd),
    .cmd_push  (f_push)
  );

  // Decoupling queue.
  psle_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_push),
    .push_cmd (f_cmd),
    .full     (in_full),
    .pop      (q_pop),
    .head     (q_head),
    .avail    (q_avail)
  );

  // Line editing and result output.
  psle_back #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (q_head),
    .cmd_avail      (q_avail),
    .cmd_pop        (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_event_kind (out_event_kind),
    .out_char_code  (out_char_code),
    .out_cursor_pos (out_cursor_pos),
    .out_line_len   (out_line_len),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for ps2_scancode_line_editor: scan code items in, edit events out.
// Predicts every event from its own line editor model and checks it field by field.
// Depends on psle_pkg and the ps2_scancode_line_editor RTL.

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import psle_pkg::*;

  localparam int LINE_CAP     = 64;
  localparam int SETTLE       = LINE_CAP + 16;
  localparam int CYCLE_LIMIT  = 2_000_000;

  // Scan codes used by the stimulus that the package does not name.
  localparam logic [7:0] SC_ESC   = 8'h01;
  localparam logic [7:0] SC_BKSP  = 8'h0E;
  localparam logic [7:0] SC_TAB   = 8'h0F;
  localparam logic [7:0] SC_ENTER = 8'h1C;
  localparam logic [7:0] SC_BREAK = 8'h80;

  localparam logic [CharW-1:0] CH_ESC = 7'h1B;
  localparam logic [CharW-1:0] CH_TAB = 7'h09;

  // Key maps for make codes 0x00 to 0x39; control and empty slots are decoded separately.
  localparam string PLAIN_KEYS   = "  1234567890-=  qwertyuiop[]  asdfghjkl;'` \\zxcvbnm,./ *  ";
  localparam string SHIFTED_KEYS = "  !@#$%^&*()_+  QWERTYUIOP{}  ASDFGHJKL:\"~ |ZXCVBNM<>? *  ";

  typedef struct {
    logic [KindW-1:0] kind;
    logic [CharW-1:0] ch;
    logic [PosW-1:0]  cursor;
    logic [PosW-1:0]  len;
    logic             last;
  } edit_event_t;

  logic             clk;
  logic             rst_n        = 1'b0;
  logic             in_push      = 1'b0;
  logic [7:0]       in_scan_byte = 8'h00;
  logic             out_pop      = 1'b0;
  logic             in_full;
  logic             out_empty;
  logic [KindW-1:0] out_event_kind;
  logic [CharW-1:0] out_char_code;
  logic [PosW-1:0]  out_cursor_pos;
  logic [PosW-1:0]  out_line_len;
  logic             out_last;

  // Editor state as predicted from the accepted items.
  logic             shift_down;
  logic             ext_pending;
  logic [CharW-1:0] line_buf [LINE_CAP];
  logic [PosW-1:0]  cursor;
  logic [PosW-1:0]  line_len;

  edit_event_t pending_events[$];
  int          mismatches     = 0;
  int          cycle_count    = 0;
  int          send_idle_pct  = 0;
  int          recv_idle_pct  = 0;

  ps2_scancode_line_editor #(
    .LINE_CAPACITY(LINE_CAP)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_scan_byte  (in_scan_byte),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_event_kind(out_event_kind),
    .out_char_code (out_char_code),
    .out_cursor_pos(out_cursor_pos),
    .out_line_len  (out_line_len),
    .out_last      (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Character produced by a make code under the given shift state.
  function automatic logic [CharW-1:0] key_char(input logic [6:0] idx, input logic shift_on);
    string keys;
    byte   k;
    keys = shift_on ? SHIFTED_KEYS : PLAIN_KEYS;
    case (idx)
      7'h01: return CH_ESC;
      7'h0E: return CH_BKSP;
      7'h0F: return CH_TAB;
      7'h1C: return CH_ENTER;
      7'h00, 7'h1D, 7'h2A, 7'h36, 7'h38: return CH_NONE;
      default: begin
        if (idx >= 7'h3A) return CH_NONE;
        k = keys.getc(int'(idx));
        return k[6:0];
      end
    endcase
  endfunction

  // Queue one event that reports the editor state after the edit.
  function automatic void add_event(input logic [KindW-1:0] kind, input logic [CharW-1:0] ch,
                                    input logic last);
    edit_event_t ev;
    ev.kind   = kind;
    ev.ch     = ch;
    ev.cursor = cursor;
    ev.len    = line_len;
    ev.last   = last;
    pending_events.push_back(ev);
  endfunction

  // Advance the predicted editor by one accepted scan code and queue its events.
  function automatic void predict_scan(input logic [7:0] code);
    logic [CharW-1:0] c;
    int               n;
    if (code == SC_PREFIX) begin
      ext_pending = 1'b1;
      return;
    end
    // Extended codes: only the arrows do anything.
    if (ext_pending) begin
      ext_pending = 1'b0;
      if (code == SC_LEFT && cursor != 0) begin
        cursor--;
        add_event(EV_LEFT, CH_NONE, 1'b1);
      end else if (code == SC_RIGHT && cursor < line_len) begin
        cursor++;
        add_event(EV_RIGHT, CH_NONE, 1'b1);
      end
      return;
    end
    if (code == SC_LSHIFT || code == SC_RSHIFT) shift_down = 1'b1;
    if (code == SC_LSHIFT_BRK || code == SC_RSHIFT_BRK) shift_down = 1'b0;
    if (code[7]) return;
    c = key_char(code[6:0], shift_down);
    if (c == CH_BKSP) begin
      if (line_len != 0 && cursor != 0) begin
        cursor--;
        line_len--;
        for (int i = cursor; i < line_len; i++) line_buf[i] = line_buf[i + 1];
        add_event(EV_DELETE, CH_NONE, 1'b1);
      end
    end else if (c == CH_ENTER) begin
      n = line_len;
      line_len = '0;
      cursor = '0;
      for (int i = 0; i < n; i++) add_event(EV_CHAR, line_buf[i], 1'b0);
      add_event(EV_END, CH_NONE, 1'b1);
    end else if (c != CH_NONE && line_len < LINE_CAP - 1) begin
      for (int i = line_len; i > cursor; i--) line_buf[i] = line_buf[i - 1];
      line_buf[cursor] = c;
      cursor++;
      line_len++;
      add_event(EV_INSERT, c, 1'b1);
    end
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endfunction

  task automatic check_event();
    edit_event_t want;
    if (pending_events.size() == 0) begin
      $display("%0t: unexpected event, expected none, got kind %0d char %0d", $time,
               out_event_kind, out_char_code);
      mismatches++;
    end else begin
      want = pending_events.pop_front();
      check_field("event_kind", want.kind, out_event_kind);
      check_field("char_code", want.ch, out_char_code);
      check_field("cursor_pos", want.cursor, out_cursor_pos);
      check_field("line_len", want.len, out_line_len);
      check_field("last", want.last, out_last);
    end
  endtask

  // Event side: check each popped event and stall pop at random.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) check_event();
    out_pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Send one scan code item, with a random gap in front of it.
  task automatic send_scan(input logic [7:0] code);
    if ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_push      <= 1'b1;
    in_scan_byte <= code;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_scan(code);
  endtask

  // Hold off the sender until every predicted event has been popped and the block settles.
  task automatic drain_events();
    in_push <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [7:0] random_char_key();
    logic [7:0] k;
    do k = 8'($urandom_range(8'h01, 8'h39));
    while (k == SC_BKSP || k == SC_ENTER || key_char(k[6:0], 1'b0) == CH_NONE);
    return k;
  endfunction

  // Every edit kind and the corner cases of the editor on a short line.
  task automatic test_directed();
    logic [7:0] seq [30] = '{
      SC_ENTER, SC_BKSP, SC_PREFIX, SC_LEFT, SC_PREFIX, SC_RIGHT, 8'h00, 8'h7F, 8'hFF,
      SC_ESC, SC_TAB, SC_LSHIFT, 8'h10, SC_LSHIFT_BRK, SC_RSHIFT, 8'h02, SC_RSHIFT_BRK,
      8'h10, SC_PREFIX, SC_PREFIX, SC_LEFT, SC_PREFIX, SC_LSHIFT, 8'h11, SC_PREFIX,
      SC_RIGHT, SC_BKSP, 8'h39, SC_BKSP, SC_ENTER
    };
    foreach (seq[i]) send_scan(seq[i]);
  endtask

  // Fill the line past capacity, try edits on a full line, then emit it.
  task automatic test_full_line();
    for (int i = 0; i < LINE_CAP + 2; i++) send_scan(random_char_key());
    repeat (3) begin
      send_scan(SC_PREFIX);
      send_scan(SC_LEFT);
    end
    send_scan(random_char_key());
    repeat (4) begin
      send_scan(SC_PREFIX);
      send_scan(SC_RIGHT);
    end
    send_scan(SC_ENTER);
  endtask

  // Mostly typing with edits and line ends, some stray and broken codes mixed in.
  task automatic test_random_typing(input int actions);
    int roll;
    for (int i = 0; i < actions; i++) begin
      roll = $urandom_range(99);
      if (roll < 45) begin
        send_scan(random_char_key());
      end else if (roll < 55) begin
        case ($urandom_range(3))
          0: send_scan(SC_LSHIFT);
          1: send_scan(SC_RSHIFT);
          2: send_scan(SC_LSHIFT_BRK);
          default: send_scan(SC_RSHIFT_BRK);
        endcase
      end else if (roll < 70) begin
        send_scan(SC_PREFIX);
        send_scan($urandom_range(1) ? SC_LEFT : SC_RIGHT);
      end else if (roll < 80) begin
        send_scan(SC_BKSP);
      end else if (roll < 85) begin
        send_scan(SC_ENTER);
      end else if (roll < 90) begin
        send_scan(SC_BREAK | random_char_key());
      end else if (roll < 95) begin
        send_scan(8'($urandom_range(255)));
      end else begin
        send_scan(SC_PREFIX);
        send_scan(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    shift_down  = 1'b0;
    ext_pending = 1'b0;
    cursor      = '0;
    line_len    = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 34;
    recv_idle_pct = 47;
    test_directed();
    test_full_line();
    drain_events();

    send_idle_pct = 47;
    recv_idle_pct = 34;
    test_random_typing(60);
    drain_events();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_typing(60);
    drain_events();

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* ps2_scancode_line_editor.f */
rtl/psle_pkg.sv
rtl/psle_front.sv
rtl/psle_cmdq.sv
rtl/psle_back.sv
rtl/ps2_scancode_line_editor.sv
dv/tb.sv
